// ----- hdl/rtuv_pkg.sv -----
// Package: shared types and codes for the rank-to-unexcluded-value unit.
package rtuv_pkg;

  // Item selector codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_PICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_DUP   = 3'd3,
    ST_RANK  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_t;

  // Which search the shared search loop is running
  typedef enum logic [1:0] {
    PH_INSERT,
    PH_BOUND,
    PH_GAP
  } phase_t;

  localparam int STATUS_W = 3;

endpackage

// ----- hdl/rtuv_in_if.sv -----
// Interface: input item channel (selector, value to insert, rank).
interface rtuv_in_if #(
  parameter int VALUE_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] entry_value;
  logic [VALUE_BITS-1:0] rank;

  modport source (output valid, output op, output entry_value, output rank, input ready);
  modport sink   (input valid, input op, input entry_value, input rank, output ready);
endinterface

// ----- hdl/rtuv_out_if.sv -----
// Interface: result item channel (picked value, status).
interface rtuv_out_if #(
  parameter int VALUE_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] picked_value;
  logic [2:0]            status;

  modport source (output valid, output picked_value, output status, input ready);
  modport sink   (input valid, input picked_value, input status, output ready);
endinterface

// ----- hdl/rank_to_unexcluded_value_unit.sv -----
// Rank-to-unexcluded-value unit: sorted exclusion table in RAM, searched by rank.
// Clear, unused selector, full or range insert go straight to the result; other items
//   run binary searches of the table (each step reads in S_SRCH and compares in S_CMP).
// Insert then shifts entries up one slot and writes the new value; pick runs two
//   searches, bound then gap. One item at a time; a stalled result waits.
// Reset clears the entry count and sets range_size to 1073741823; table is not cleared.
module rank_to_unexcluded_value_unit
  import rtuv_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata,
  rtuv_in_if.sink               req,
  rtuv_out_if.source            rsp
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W = ((VALUE_BITS > CNT_W) ? VALUE_BITS : CNT_W) + 1;
  localparam logic [VALUE_BITS-1:0] RANGE_RESET = VALUE_BITS'(64'd1073741823);
  localparam logic [CNT_W-1:0]      CNT_MAX     = CNT_W'(MAX_ENTRIES);

  state_t                state, state_next;
  phase_t                phase;
  logic [VALUE_BITS-1:0] range_size;
  logic [CNT_W-1:0]      count;
  logic [VALUE_BITS-1:0] key;
  logic [CNT_W-1:0]      lo, hi, mid;
  logic                  dup;
  logic [IDX_W-1:0]      dst, pos, pend_addr;
  logic                  pend;
  logic [VALUE_BITS-1:0] res_value;
  status_t               res_status;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic [2:0]            out_status;

  logic                  accept;
  logic                  srch_live;
  logic [CNT_W-1:0]      mid_calc;
  logic [SUM_W-1:0]      key_plus_lo, key_plus_mid;
  logic                  rank_bad;
  logic                  go_right;
  logic                  ins_full, ins_range;
  logic                  out_load;
  op_t                   req_op;

  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wr_data, rd_data;

  rtuv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // handshake and shared arithmetic
  assign req.ready    = (state == S_IDLE) && !rst;
  assign accept       = req.valid && req.ready;
  assign req_op       = op_t'(req.op);
  assign srch_live    = (lo < hi);
  assign mid_calc     = lo + ((hi - lo) >> 1);
  assign key_plus_lo  = SUM_W'(key) + SUM_W'(lo);
  assign key_plus_mid = SUM_W'(key) + SUM_W'(mid);
  assign rank_bad     = (key_plus_lo >= SUM_W'(range_size));
  assign ins_full     = (count >= CNT_MAX);
  assign ins_range    = (req.entry_value >= range_size);
  assign out_load     = (state == S_DONE) && (!out_valid || rsp.ready);

  // step direction of the binary search
  always_comb begin
    unique case (phase)
      PH_INSERT: go_right = (rd_data < key);
      PH_BOUND:  go_right = (rd_data < range_size);
      PH_GAP:    go_right = (SUM_W'(rd_data) <= key_plus_mid);
      default:   go_right = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_op)
            OP_INSERT: state_next = (ins_full || ins_range) ? S_DONE : S_SRCH;
            OP_PICK:   state_next = S_SRCH;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (srch_live) begin
          state_next = S_CMP;
        end else begin
          unique case (phase)
            PH_INSERT: state_next = dup ? S_DONE : S_SHIFT;
            PH_BOUND:  state_next = rank_bad ? S_DONE : S_SRCH;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_CMP: state_next = S_SRCH;
      S_SHIFT: begin
        if (!pend && (dst == pos)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_calc[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = key;
    unique case (state)
      S_SRCH: rd_en = srch_live;
      S_SHIFT: begin
        rd_en   = (dst > pos);
        rd_addr = dst - 1'b1;
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = rd_data;
        end else if (dst == pos) begin
          wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      range_size <= RANGE_RESET;
      count      <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        range_size <= cfg_wdata;
      end
      if (accept && (req_op == OP_CLEAR)) begin
        count <= '0;
      end
      if (state == S_SHIFT) begin
        pend <= (dst > pos);
        if (!pend && (dst == pos)) begin
          count <= count + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search, shift and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key        <= (req_op == OP_PICK) ? req.rank : req.entry_value;
          lo         <= '0;
          hi         <= count;
          dup        <= 1'b0;
          res_value  <= '0;
          res_status <= ST_OK;
          phase      <= (req_op == OP_PICK) ? PH_BOUND : PH_INSERT;
          if (req_op == OP_INSERT) begin
            if (ins_full) begin
              res_status <= ST_FULL;
            end else if (ins_range) begin
              res_status <= ST_RANGE;
            end
          end
        end
      end
      S_SRCH: begin
        if (srch_live) begin
          mid <= mid_calc;
        end else begin
          unique case (phase)
            PH_INSERT: begin
              if (dup) begin
                res_status <= ST_DUP;
              end
              dst <= count[IDX_W-1:0];
              pos <= lo[IDX_W-1:0];
            end
            PH_BOUND: begin
              if (rank_bad) begin
                res_status <= ST_RANK;
              end else begin
                // second pass over the entries below range_size
                hi    <= lo;
                lo    <= '0;
                phase <= PH_GAP;
              end
            end
            default: res_value <= key_plus_lo[VALUE_BITS-1:0];
          endcase
        end
      end
      S_CMP: begin
        if (go_right) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
        if ((phase == PH_INSERT) && (rd_data == key)) begin
          dup <= 1'b1;
        end
      end
      S_SHIFT: begin
        // move entries up one slot, top first
        if (dst > pos) begin
          pend_addr <= dst;
          dst       <= dst - 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.picked_value = out_value;
  assign rsp.status       = out_status;

endmodule

// ----- hdl/rtuv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rtuv_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- dv/tb_rank_to_unexcluded_value_unit.sv -----
// Testbench for the rank-to-unexcluded-value unit: directed and random items, shadow table check.
`timescale 1ns / 100ps
module tb_rank_to_unexcluded_value_unit;
  import rtuv_pkg::*;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 30;
  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef logic [VALUE_BITS-1:0] val_t;

  localparam val_t VAL_MAX = '1;

  // One answer of the unit: picked value and status
  typedef struct packed {
    val_t    picked;
    status_t status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  val_t cfg_wdata;

  rtuv_in_if  #(.VALUE_BITS(VALUE_BITS)) req_if ();
  rtuv_out_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

  rank_to_unexcluded_value_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // Shadow copy of the exclusion table, its fill and the range register
  val_t    excluded_vals [MAX_ENTRIES];
  int      excluded_count = 0;
  val_t    range_n = VAL_MAX;
  answer_t answers_due [$];
  int      mismatch_count = 0;
  bit      quiet_mode = 1'b0;
  longint  cycle_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Number of excluded values that lie below the current range
  function automatic int count_in_range();
    int n;
    n = 0;
    while (n < excluded_count && excluded_vals[n] < range_n) n++;
    return n;
  endfunction

  // Applies one item to the shadow table and returns the answer it must produce
  function automatic answer_t rank_lookup_answer(input op_t op, input val_t val, input val_t rk);
    answer_t a;
    int      pos;
    int      below;
    int      i;
    longint  free_cnt;
    a.picked = '0;
    a.status = ST_OK;
    case (op)
      OP_CLEAR: excluded_count = 0;
      OP_INSERT: begin
        if (excluded_count >= MAX_ENTRIES) begin
          a.status = ST_FULL;
        end else if (val >= range_n) begin
          a.status = ST_RANGE;
        end else begin
          pos = 0;
          while (pos < excluded_count && excluded_vals[pos] < val) pos++;
          if (pos < excluded_count && excluded_vals[pos] == val) begin
            a.status = ST_DUP;
          end else begin
            for (i = excluded_count; i > pos; i--) excluded_vals[i] = excluded_vals[i-1];
            excluded_vals[pos] = val;
            excluded_count++;
          end
        end
      end
      OP_PICK: begin
        below    = count_in_range();
        free_cnt = longint'(range_n) - below;
        if (longint'(rk) >= free_cnt) begin
          a.status = ST_RANK;
        end else begin
          // first entry whose gap (value minus index) exceeds the rank
          i = 0;
          while (i < below && longint'(excluded_vals[i]) - i <= longint'(rk)) i++;
          a.picked = rk + val_t'(i);
        end
      end
      OP_NOP: ;
    endcase
    return a;
  endfunction

  // Rank with a bias toward free-count edges and gap boundaries of the table
  function automatic val_t pick_rank();
    int     below;
    int     j;
    int     d;
    longint free_cnt;
    longint r;
    below    = count_in_range();
    free_cnt = longint'(range_n) - below;
    case ($urandom_range(0, 5))
      0: r = $urandom;
      1: r = free_cnt;
      2: r = free_cnt - 1;
      3, 4: begin
        if (below > 0) begin
          j = $urandom_range(0, below - 1);
          d = $urandom_range(0, 2);
          r = longint'(excluded_vals[j]) - j + d - 1;
        end else begin
          r = $urandom_range(0, 3);
        end
      end
      default: r = (free_cnt > 0) ? longint'($urandom_range(0, free_cnt - 1)) : 0;
    endcase
    if (r < 0) r = 0;
    return val_t'(r);
  endfunction

  // Offers one item, waits for the handshake, records the answer it must get
  task automatic send_item(input op_t op, input val_t val, input val_t rk);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.entry_value <= val;
    req_if.rank        <= rk;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    answers_due.push_back(rank_lookup_answer(op, val, rk));
  endtask

  // Drops valid and holds until every outstanding answer is back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Range register write, only with the unit idle
  task automatic write_range(input val_t n);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    range_n = n;
  endtask

  // Random item of any kind, values biased to the current range and table
  task automatic send_random_item();
    int   sel;
    val_t val;
    sel = $urandom_range(0, 19);
    val = val_t'($urandom);
    if (sel == 0) begin
      send_item(OP_CLEAR, val, val_t'($urandom));
    end else if (sel == 1) begin
      send_item(OP_NOP, val, val_t'($urandom));
    end else if (sel < 11) begin
      case ($urandom_range(0, 7))
        0: ;
        1: if (excluded_count > 0) val = excluded_vals[$urandom_range(0, excluded_count - 1)];
        default: val = val_t'($urandom_range(0, (range_n < VAL_MAX - 3) ? range_n + 3 : VAL_MAX));
      endcase
      send_item(OP_INSERT, val, val_t'($urandom));
    end else begin
      send_item(OP_PICK, val, pick_rank());
    end
  endtask

  // Field extremes, every selector and every status but full at the reset range
  task automatic test_directed_basics();
    send_item(OP_PICK, VAL_MAX, '0);
    send_item(OP_PICK, '0, VAL_MAX - 1);
    send_item(OP_PICK, VAL_MAX, VAL_MAX);
    send_item(OP_INSERT, VAL_MAX, VAL_MAX);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, VAL_MAX - 1, '0);
    send_item(OP_INSERT, '0, VAL_MAX);
    send_item(OP_INSERT, 30'd5, '0);
    // the sender goes quiet until the unit has answered everything
    wait_drained();
    send_item(OP_PICK, '0, '0);
    send_item(OP_PICK, '0, 30'd3);
    send_item(OP_PICK, VAL_MAX, 30'd4);
    send_item(OP_PICK, '0, VAL_MAX - 4);
    send_item(OP_PICK, '0, VAL_MAX - 3);
    send_item(OP_NOP, VAL_MAX, VAL_MAX);
    send_item(OP_INSERT, VAL_MAX - 2, '0);
    send_item(OP_PICK, '0, VAL_MAX - 5);
    send_item(OP_CLEAR, val_t'($urandom), val_t'($urandom));
    send_item(OP_PICK, '0, 30'd7);
    send_item(OP_NOP, '0, '0);
  endtask

  // Random mix over four small ranges and then the reset range, table kept across range changes
  task automatic test_random_mix();
    int ph;
    int n;
    for (ph = 0; ph < 5; ph++) begin
      write_range((ph == 4) ? VAL_MAX : val_t'($urandom_range(8, 64)));
      for (n = 0; n < 50; n++) begin
        send_random_item();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
  endtask

  // Grows the table to capacity, mostly in ascending order, then hits the full case
  task automatic test_fill_to_full();
    val_t frontier;
    int   sel;
    int   n;
    write_range(VAL_MAX);
    send_item(OP_CLEAR, val_t'($urandom), val_t'($urandom));
    frontier = val_t'($urandom_range(0, 255));
    while (excluded_count < MAX_ENTRIES) begin
      sel = $urandom_range(0, 63);
      if (sel < 4) begin
        send_item(OP_PICK, val_t'($urandom), pick_rank());
      end else if (sel == 4 && excluded_count > 0) begin
        send_item(OP_INSERT, excluded_vals[$urandom_range(0, excluded_count - 1)],
                  val_t'($urandom));
      end else if (sel == 5 && $urandom_range(0, 1) == 0) begin
        // usually lands mid-table, so the unit has to shift entries up
        send_item(OP_INSERT, val_t'($urandom_range(0, frontier)), val_t'($urandom));
      end else begin
        send_item(OP_INSERT, frontier, val_t'($urandom));
        frontier += val_t'($urandom_range(1, 1 << 19));
      end
    end
    // full takes priority over out-of-range and duplicate
    send_item(OP_INSERT, val_t'($urandom), val_t'($urandom));
    send_item(OP_INSERT, VAL_MAX, val_t'($urandom));
    send_item(OP_INSERT, excluded_vals[0], val_t'($urandom));
    for (n = 0; n < 12; n++) send_item(OP_PICK, val_t'($urandom), pick_rank());
  endtask

  // Range moved across a full table, mostly below part of it: only entries under the range count
  task automatic test_range_shrink();
    val_t sizes [5];
    int   s;
    int   n;
    sizes[0] = excluded_vals[MAX_ENTRIES/2];
    sizes[1] = excluded_vals[MAX_ENTRIES/2] + 1;
    sizes[2] = excluded_vals[MAX_ENTRIES-1] + 1;
    sizes[3] = val_t'($urandom_range(1, excluded_vals[MAX_ENTRIES-1]));
    sizes[4] = 30'd1;
    for (s = 0; s < 5; s++) begin
      write_range(sizes[s]);
      for (n = 0; n < 8; n++) send_item(OP_PICK, val_t'($urandom), pick_rank());
      send_item(OP_INSERT, val_t'($urandom), '0);
      send_item(OP_INSERT, VAL_MAX, '0);
    end
  endtask

  // Smallest range on an empty and a one-entry table
  task automatic test_min_range();
    write_range(30'd1);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_PICK, '0, '0);
    send_item(OP_PICK, '0, 30'd1);
    send_item(OP_PICK, '0, VAL_MAX);
    send_item(OP_INSERT, 30'd1, '0);
    send_item(OP_INSERT, VAL_MAX, '0);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_PICK, '0, '0);
    send_item(OP_CLEAR, VAL_MAX, VAL_MAX);
    send_item(OP_PICK, '0, '0);
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_quiet_tail();
    int n;
    write_range(val_t'($urandom_range(16, 1000)));
    quiet_mode = 1'b1;
    for (n = 0; n < 80; n++) send_random_item();
  endtask

  // Result side: random stall bursts unless quiet
  initial begin : rsp_stall_gen
    int n;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_mode && $urandom_range(0, 15) == 0) begin
        rsp_if.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Each accepted result against the oldest outstanding answer
  always @(posedge clk) begin : answer_check
    answer_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (answers_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none outstanding: expected none, got value %0d status %0d",
                 $time, rsp_if.picked_value, rsp_if.status);
      end else begin
        want = answers_due.pop_front();
        if (rsp_if.picked_value !== want.picked) begin
          mismatch_count++;
          $display("%0t: picked_value mismatch: expected %0d, got %0d",
                   $time, want.picked, rsp_if.picked_value);
        end
        if (rsp_if.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp_if.status);
        end
      end
    end
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d answers outstanding",
             $time, cycle_count, answers_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_NOP;
    req_if.entry_value <= '0;
    req_if.rank        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_random_mix();
    test_fill_to_full();
    test_range_shrink();
    test_min_range();
    test_quiet_tail();

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- rank_to_unexcluded_value_unit.f -----
hdl/rtuv_pkg.sv
hdl/rtuv_in_if.sv
hdl/rtuv_out_if.sv
hdl/rtuv_ram.sv
hdl/rank_to_unexcluded_value_unit.sv
dv/tb_rank_to_unexcluded_value_unit.sv
